// ===== hw/rtl/hkit_pkg.sv =====
`default_nettype none

package hkit_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 4096;
    localparam int BLOCK_SLOTS = 128;
    localparam int MAX_PROBES  = 19;

    localparam int MAX_BLOCKS  = TABLE_DEPTH / BLOCK_SLOTS;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int BLOCK_W     = $clog2(BLOCK_SLOTS);
    localparam int REM_W       = SLOT_W - BLOCK_W;
    localparam int BLKS_W      = REM_W + 1;
    localparam int SIZE_W      = SLOT_W + 1;
    localparam int CNT_W       = SLOT_W + 1;
    localparam int TRY_W       = $clog2(MAX_PROBES + 1);

    // Fixed field widths
    localparam int KEY_W       = 31;
    localparam int HASH_W      = 32;
    localparam int ENTRY_W     = KEY_W + 1;
    localparam int CFG_W       = 6;
    localparam int CFG_RESET   = 32;

    // Remainder unit: MOD_DIGITS dividend bits per cycle
    localparam int HI_W        = HASH_W - BLOCK_W;
    localparam int MOD_DIGITS  = 5;
    localparam int MOD_STEPS   = (HI_W + MOD_DIGITS - 1) / MOD_DIGITS;
    localparam int MOD_PAD_W   = MOD_STEPS * MOD_DIGITS;
    localparam int MIX_STEPS   = 3;
    localparam int HSTEP_W     = $clog2((MOD_STEPS > MIX_STEPS ? MOD_STEPS : MIX_STEPS) + 1);

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_FINISH = 2'd2,
        MODE_LOOKUP = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [KEY_W-1:0]   key;
    } t_cmd;

    typedef struct packed {
        logic               success;
        logic [SLOT_W-1:0]  slot;
        logic [SLOT_W-1:0]  rank;
        logic [CNT_W-1:0]   entry_count;
    } t_res;

    typedef struct packed {
        logic               start;
        logic [HASH_W-1:0]  probe;
    } t_hash_req;

    typedef struct packed {
        logic               done;
        logic [SLOT_W-1:0]  slot;
    } t_hash_rsp;

endpackage

`default_nettype wire

// ===== hw/rtl/hkit_ram.sv =====
`default_nettype none

module hkit_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/hkit_hash.sv =====
`default_nettype none

module hkit_hash (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire hkit_pkg::t_hash_req        i_req,
    input  wire logic [hkit_pkg::BLKS_W-1:0] i_blocks,
    output hkit_pkg::t_hash_rsp             o_rsp
);

    import hkit_pkg::*;

    typedef enum logic [1:0] {
        H_IDLE,
        H_MIX,
        H_MOD
    } t_hstate;

    t_hstate               r_state;
    logic [HSTEP_W-1:0]    r_cnt;
    logic [HASH_W-1:0]     r_h;
    logic [MOD_PAD_W-1:0]  r_q;
    logic [BLOCK_W-1:0]    r_lo;
    logic [REM_W-1:0]      r_rem;
    logic                  r_done;
    logic [SLOT_W-1:0]     r_slot;

    logic [HASH_W-1:0]     n_h;
    logic [REM_W-1:0]      n_rem;

    // One add/xor-shift pair of the integer mix
    function automatic logic [HASH_W-1:0] mix_step(input logic [HASH_W-1:0] h,
                                                  input logic [HSTEP_W-1:0] k);
        logic [HASH_W-1:0] s;
        s = h;
        case (k)
            HSTEP_W'(0): begin
                s = h + ~(h << 15);
                s = s ^ HASH_W'($signed(s) >>> 10);
            end
            HSTEP_W'(1): begin
                s = h + (h << 3);
                s = s ^ HASH_W'($signed(s) >>> 6);
            end
            default: begin
                s = h + ~(h << 11);
                s = s ^ HASH_W'($signed(s) >>> 16);
            end
        endcase
        return s;
    endfunction

    assign n_h = mix_step(r_h, r_cnt);

    // Restoring remainder, MOD_DIGITS bits of the upper hash per cycle
    always_comb begin
        logic [REM_W:0] t;
        n_rem = r_rem;
        for (int i = 0; i < MOD_DIGITS; i++) begin
            t = {n_rem, r_q[MOD_PAD_W-1-i]};
            if (t >= i_blocks) begin
                t = t - i_blocks;
            end
            n_rem = t[REM_W-1:0];
        end
    end

    // Sequencer: load, mix, reduce
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                H_IDLE: begin
                    if (i_req.start) begin
                        r_h     <= i_req.probe;
                        r_cnt   <= '0;
                        r_state <= H_MIX;
                    end
                end
                H_MIX: begin
                    r_h   <= n_h;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == HSTEP_W'(MIX_STEPS - 1)) begin
                        r_q     <= MOD_PAD_W'(n_h[HASH_W-1:BLOCK_W]);
                        r_lo    <= n_h[BLOCK_W-1:0];
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= H_MOD;
                    end
                end
                H_MOD: begin
                    r_q   <= r_q << MOD_DIGITS;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == HSTEP_W'(MOD_STEPS - 1)) begin
                        r_slot  <= {n_rem, r_lo};
                        r_done  <= 1'b1;
                        r_state <= H_IDLE;
                    end
                end
                default: begin
                    r_state <= H_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.slot = r_slot;

endmodule

`default_nettype wire

// ===== hw/rtl/hashed_key_index_table.sv =====
// Hashed key index table: open-addressing store of 31-bit keys.
// Command channel (i_cmd_valid / o_cmd_ready, payload i_cmd) carries a mode
// and a key: clear, insert, finish numbering or lookup. Every command gives
// exactly one transfer on the result channel (o_res_valid / i_res_ready).
// The table size is written on the config channel (i_cfg_valid, always
// ready) in units of 128 slots; 0 counts as 1, values above 32 as 32.
// Commands are handled one at a time. Each probe runs the mix and the
// remainder steps in the hash unit, then one key RAM read and a compare
// (19 probes at most for insert and lookup; lookup adds a rank RAM read).
// Finish walks the active slots through the key RAM read port. Clear
// writes all 4096 entries, one per cycle.
// After reset the same clearing pass runs with o_cmd_ready low.
// The result sits in an output register: a new command is taken while it
// waits, and a finished command waits in its last state until the receiver
// has taken the previous result.
`default_nettype none

module hashed_key_index_table (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cmd_valid,
    output logic                             o_cmd_ready,
    input  wire hkit_pkg::t_cmd              i_cmd,
    output logic                             o_res_valid,
    input  wire logic                        i_res_ready,
    output hkit_pkg::t_res                   o_res,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [hkit_pkg::CFG_W-1:0]  i_cfg_data
);

    import hkit_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_CHECK,
        S_RANK,
        S_FIN,
        S_RESP
    } t_state;

    t_state              r_state;
    t_mode               r_mode;
    logic [KEY_W-1:0]    r_key;
    logic [HASH_W-1:0]   r_probe;
    logic [TRY_W-1:0]    r_tries;
    logic [SIZE_W-1:0]   r_addr;
    logic                r_pend;
    logic [SLOT_W-1:0]   r_pend_addr;
    logic [CNT_W-1:0]    r_count;
    logic [SLOT_W-1:0]   r_slot;
    t_res                r_acc;
    t_res                r_out;
    logic                r_out_valid;
    logic                r_hash_start;
    logic                r_clr_cmd;
    logic [CFG_W-1:0]    r_cfg;

    logic [CFG_W-1:0]    cfg_clamp;
    logic [BLKS_W-1:0]   blocks;
    logic [SIZE_W-1:0]   size;
    logic                fin_more;

    t_hash_req           hash_req;
    t_hash_rsp           hash_rsp;

    logic                key_we;
    logic [SLOT_W-1:0]   key_waddr;
    logic [ENTRY_W-1:0]  key_wdata;
    logic                key_re;
    logic [SLOT_W-1:0]   key_raddr;
    logic [ENTRY_W-1:0]  key_rdata;
    logic                k_used;
    logic                k_match;

    logic                rank_we;
    logic                rank_re;
    logic [SLOT_W-1:0]   rank_rdata;

    // Active table size
    always_comb begin
        if (r_cfg == '0) begin
            cfg_clamp = CFG_W'(1);
        end else if (int'(r_cfg) > MAX_BLOCKS) begin
            cfg_clamp = CFG_W'(MAX_BLOCKS);
        end else begin
            cfg_clamp = r_cfg;
        end
    end

    assign blocks   = BLKS_W'(cfg_clamp);
    assign size     = {blocks, BLOCK_W'(0)};
    assign fin_more = (r_addr < size);

    // Hash and reduce unit
    assign hash_req.start = r_hash_start;
    assign hash_req.probe = r_probe;

    hkit_hash u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (hash_req),
        .i_blocks (blocks),
        .o_rsp    (hash_rsp)
    );

    // Key store: valid bit over the key
    hkit_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_re    (key_re),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    // Rank store, written by finish only
    hkit_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (rank_we),
        .i_waddr (r_pend_addr),
        .i_wdata (r_count[SLOT_W-1:0]),
        .i_re    (rank_re),
        .i_raddr (r_slot),
        .o_rdata (rank_rdata)
    );

    assign k_used  = key_rdata[KEY_W];
    assign k_match = k_used && (key_rdata[KEY_W-1:0] == r_key);

    // Memory port control
    always_comb begin
        key_we    = 1'b0;
        key_waddr = r_slot;
        key_wdata = {1'b1, r_key};
        key_re    = 1'b0;
        key_raddr = hash_rsp.slot;
        rank_we   = 1'b0;
        rank_re   = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                key_we    = 1'b1;
                key_waddr = r_addr[SLOT_W-1:0];
                key_wdata = '0;
            end
            S_HASH: begin
                key_re = hash_rsp.done;
            end
            S_CHECK: begin
                key_we  = (r_mode == MODE_INSERT) && !k_used;
                rank_re = (r_mode == MODE_LOOKUP) && k_match;
            end
            S_FIN: begin
                key_re    = fin_more;
                key_raddr = r_addr[SLOT_W-1:0];
                rank_we   = r_pend && k_used;
            end
            default: begin
            end
        endcase
    end

    // Command sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_addr       <= '0;
            r_pend       <= 1'b0;
            r_clr_cmd    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_hash_start <= 1'b0;
            r_tries      <= '0;
            r_cfg        <= CFG_W'(CFG_RESET);
        end else begin
            r_hash_start <= 1'b0;
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
            if (r_out_valid && i_res_ready && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr[SLOT_W-1:0] == '1) begin
                        r_addr  <= '0;
                        r_acc   <= '0;
                        r_state <= r_clr_cmd ? S_RESP : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_mode  <= i_cmd.mode;
                        r_key   <= i_cmd.key;
                        r_probe <= HASH_W'(i_cmd.key);
                        r_tries <= '0;
                        r_acc   <= '0;
                        r_addr  <= '0;
                        r_count <= '0;
                        r_pend  <= 1'b0;
                        unique case (i_cmd.mode)
                            MODE_CLEAR: begin
                                r_clr_cmd <= 1'b1;
                                r_state   <= S_CLEAR;
                            end
                            MODE_INSERT, MODE_LOOKUP: begin
                                r_hash_start <= 1'b1;
                                r_state      <= S_HASH;
                            end
                            MODE_FINISH: begin
                                r_state <= S_FIN;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_HASH: begin
                    if (hash_rsp.done) begin
                        r_slot  <= hash_rsp.slot;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if ((r_mode == MODE_INSERT) && (k_match || !k_used)) begin
                        r_acc.success <= 1'b1;
                        r_acc.slot    <= r_slot;
                        r_state       <= S_RESP;
                    end else if ((r_mode == MODE_LOOKUP) && k_match) begin
                        r_acc.success <= 1'b1;
                        r_state       <= S_RANK;
                    end else if (r_tries == TRY_W'(MAX_PROBES - 1)) begin
                        // probes exhausted: all-zero result
                        r_state <= S_RESP;
                    end else begin
                        r_probe      <= r_probe + HASH_W'(2);
                        r_tries      <= r_tries + 1'b1;
                        r_hash_start <= 1'b1;
                        r_state      <= S_HASH;
                    end
                end
                S_RANK: begin
                    r_acc.rank <= rank_rdata;
                    r_state    <= S_RESP;
                end
                S_FIN: begin
                    // read slot r_addr, number the slot read in the previous cycle
                    r_pend      <= fin_more;
                    r_pend_addr <= r_addr[SLOT_W-1:0];
                    if (fin_more) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    if (r_pend && k_used) begin
                        r_count <= r_count + 1'b1;
                    end
                    if (!fin_more && !r_pend) begin
                        r_acc.entry_count <= r_count;
                        r_state           <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (!r_out_valid || i_res_ready) begin
                        r_out       <= r_acc;
                        r_out_valid <= 1'b1;
                        r_clr_cmd   <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;
    assign o_cfg_ready = 1'b1;

    // Rank store is written only while numbering
    a_rank_write_in_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rank_we |-> (r_state == S_FIN))
        else $error("rank store written outside finish");

    // A key write outside the clearing pass places a valid key for an insert
    a_key_write_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (key_we && (r_state != S_CLEAR)) |-> (key_wdata[KEY_W] && (r_mode == MODE_INSERT)))
        else $error("key store write outside insert");

    // Hash results arrive only while waiting for them
    a_hash_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hash_rsp.done |-> (r_state == S_HASH))
        else $error("hash result while not waiting");

    // Probe count never exceeds the limit
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tries < TRY_W'(MAX_PROBES))
        else $error("probe count beyond limit");

    // A result is loaded only from the response state
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_valid) |-> ($past(r_state) == S_RESP))
        else $error("result loaded outside response state");

endmodule

`default_nettype wire
